// ----- sv/iexec_pkg.sv -----
// Shared types, opcode constants and status codes for the integer executor.
package iexec_pkg;

    localparam int unsigned RF_DEPTH = 32;
    localparam int unsigned RF_ADDR_W = $clog2(RF_DEPTH);

    typedef logic [RF_ADDR_W-1:0] reg_addr_t;
    typedef logic [31:0] word_t;

    localparam word_t START_ADDRESS_RESET = 32'h0000_1000;

    // Registers with a fixed role in a system call.
    localparam reg_addr_t REG_V0 = reg_addr_t'(2);
    localparam reg_addr_t REG_A0 = reg_addr_t'(4);
    localparam reg_addr_t REG_RA = reg_addr_t'(31);

    typedef enum logic [2:0] {
        ST_RETIRED    = 3'd0,
        ST_LOAD_REQ   = 3'd1,
        ST_STORE_REQ  = 3'd2,
        ST_SYSCALL    = 3'd3,
        ST_ILLEGAL    = 3'd4,
        ST_UNEXPECTED = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        KIND_LB  = 3'd0,
        KIND_LH  = 3'd1,
        KIND_LW  = 3'd2,
        KIND_LBU = 3'd3,
        KIND_LHU = 3'd4
    } load_kind_t;

    localparam logic [1:0] ACC_BYTE = 2'd0;
    localparam logic [1:0] ACC_HALF = 2'd1;
    localparam logic [1:0] ACC_WORD = 2'd2;

    // Primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_XORI    = 6'h0e;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2b;

    // Function codes of the register-register group
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0c;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2a;
    localparam logic [5:0] FN_SLTU    = 6'h2b;

    typedef struct packed {
        word_t      pc;
        logic       load_pending;
        reg_addr_t  pending_register;
        load_kind_t pending_kind;
    } core_state_t;

    typedef struct packed {
        status_t    status;
        word_t      instr_address;
        word_t      next_address;
        logic       write_valid;
        reg_addr_t  write_register;
        word_t      write_value;
        word_t      mem_address;
        logic [1:0] access_size;
        word_t      store_value;
        word_t      call_number;
        word_t      call_argument;
    } result_t;

endpackage

// ----- sv/mips32_instruction_executor_core.sv -----
// Top level of the integer instruction executor: input register, execute, result register.
//
// Usage: each input word is either an instruction (op = 0), fetched from the last
// reported next_address, or the data for a pending load (op = 1). Every accepted
// word yields exactly one result word on the output channel, in order.
// A load request (status 1) must be answered by a data word before the next
// instruction; anything out of that order gives status 5 and changes nothing.
// An accepted word loads the input register and reads the register file; execute then
// loads the result register, which offers it on the output. The core takes one word per
// cycle while the output does not stall, set by the single pass from the input register
// through the ALU and the register file write port.
// Stalls: a held result freezes the result register; the input register still takes
// one word, and in_stall rises only when both the input and result registers are full.
// Reset clears the register file, empties both registers, and sets the program counter
// to 0x1000. A cfg_write_en pulse, given only while idle, loads the program counter
// with cfg_write_data and drops any pending load.
module mips32_instruction_executor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [31:0] instruction,
    input  logic [31:0] load_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] instr_address,
    output logic [31:0] next_address,
    output logic        write_valid,
    output logic [4:0]  write_register,
    output logic [31:0] write_value,
    output logic [31:0] mem_address,
    output logic [1:0]  access_size,
    output logic [31:0] store_value,
    output logic [31:0] call_number,
    output logic [31:0] call_argument
);
    import iexec_pkg::*;

    logic        s1_valid_reg;
    logic        op_reg;
    word_t       instruction_reg;
    word_t       load_data_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    core_state_t state_reg;

    core_state_t state_next;
    result_t     result_next;
    logic        advance;
    logic        in_accept;
    logic        fire;
    logic        is_syscall;
    reg_addr_t   rd_addr_a;
    reg_addr_t   rd_addr_b;
    word_t       src_a;
    word_t       src_b;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign fire      = s1_valid_reg && advance;

    // A system call needs v0 and a0 on the two read ports instead of rs and rt.
    assign is_syscall = (instruction[31:26] == OP_SPECIAL) && (instruction[5:0] == FN_SYSCALL);
    assign rd_addr_a  = is_syscall ? REG_V0 : instruction[25:21];
    assign rd_addr_b  = is_syscall ? REG_A0 : instruction[20:16];

    iexec_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (src_a),
        .rd_data_b (src_b),
        .wr_en     (fire && result_next.write_valid),
        .wr_addr   (result_next.write_register),
        .wr_data   (result_next.write_value)
    );

    iexec_execute u_execute (
        .op          (op_reg),
        .instruction (instruction_reg),
        .load_data   (load_data_reg),
        .src_a       (src_a),
        .src_b       (src_b),
        .cur_state   (state_reg),
        .next_state  (state_next),
        .result      (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.pc               <= START_ADDRESS_RESET;
            state_reg.load_pending     <= 1'b0;
            state_reg.pending_register <= '0;
            state_reg.pending_kind     <= KIND_LB;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end

            // Restart vector: load pc and drop any pending load.
            if (cfg_write_en)
            begin
                state_reg.pc           <= cfg_write_data;
                state_reg.load_pending <= 1'b0;
            end
            else if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg          <= op;
            instruction_reg <= instruction;
            load_data_reg   <= load_data;
        end
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = result_reg.status;
    assign instr_address  = result_reg.instr_address;
    assign next_address   = result_reg.next_address;
    assign write_valid    = result_reg.write_valid;
    assign write_register = result_reg.write_register;
    assign write_value    = result_reg.write_value;
    assign mem_address    = result_reg.mem_address;
    assign access_size    = result_reg.access_size;
    assign store_value    = result_reg.store_value;
    assign call_number    = result_reg.call_number;
    assign call_argument  = result_reg.call_argument;

endmodule

// ----- sv/iexec_regfile.sv -----
// General register file: two registered read ports, one write port, write forwarding.
module iexec_regfile (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  iexec_pkg::reg_addr_t rd_addr_a,
    input  iexec_pkg::reg_addr_t rd_addr_b,
    output iexec_pkg::word_t    rd_data_a,
    output iexec_pkg::word_t    rd_data_b,
    input  logic                wr_en,
    input  iexec_pkg::reg_addr_t wr_addr,
    input  iexec_pkg::word_t    wr_data
);
    import iexec_pkg::*;

    word_t              rf_mem [RF_DEPTH];
    logic [RF_DEPTH-1:0] valid_reg;
    word_t              rd_data_a_reg;
    word_t              rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rf_mem[wr_addr] <= wr_data;
        end
    end

    // An entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Forward a write landing on the same edge as the read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr_a))
            begin
                rd_data_a_reg <= wr_data;
            end
            else if (valid_reg[rd_addr_a])
            begin
                rd_data_a_reg <= rf_mem[rd_addr_a];
            end
            else
            begin
                rd_data_a_reg <= '0;
            end

            if (wr_en && (wr_addr == rd_addr_b))
            begin
                rd_data_b_reg <= wr_data;
            end
            else if (valid_reg[rd_addr_b])
            begin
                rd_data_b_reg <= rf_mem[rd_addr_b];
            end
            else
            begin
                rd_data_b_reg <= '0;
            end
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ----- sv/iexec_execute.sv -----
// Combinational execute step: decode, ALU, branch target, load completion, next state.
module iexec_execute (
    input  logic                   op,
    input  iexec_pkg::word_t       instruction,
    input  iexec_pkg::word_t       load_data,
    input  iexec_pkg::word_t       src_a,
    input  iexec_pkg::word_t       src_b,
    input  iexec_pkg::core_state_t cur_state,
    output iexec_pkg::core_state_t next_state,
    output iexec_pkg::result_t     result
);
    import iexec_pkg::*;

    logic [5:0] opc;
    logic [5:0] fn;
    reg_addr_t  rt;
    reg_addr_t  rd;
    logic [4:0] sh;
    word_t      imm;
    word_t      simm;
    word_t      pc_plus4;
    word_t      branch_target;
    word_t      jump_target;

    assign opc           = instruction[31:26];
    assign rt            = instruction[20:16];
    assign rd            = instruction[15:11];
    assign sh            = instruction[10:6];
    assign fn            = instruction[5:0];
    assign imm           = {16'h0000, instruction[15:0]};
    assign simm          = {{16{instruction[15]}}, instruction[15:0]};
    assign pc_plus4      = cur_state.pc + 32'd4;
    assign branch_target = pc_plus4 + {simm[29:0], 2'b00};
    assign jump_target   = {pc_plus4[31:28], instruction[25:0], 2'b00};

    always_comb
    begin
        logic      wr_req;
        reg_addr_t wr_dst;
        word_t     wr_val;
        word_t     npc;

        wr_req     = 1'b0;
        wr_dst     = '0;
        wr_val     = '0;
        npc        = pc_plus4;
        next_state = cur_state;
        result     = '0;
        result.status        = ST_RETIRED;
        result.instr_address = cur_state.pc;

        if (op)
        begin
            if (!cur_state.load_pending)
            begin
                result.status = ST_UNEXPECTED;
                npc = cur_state.pc;
            end
            else
            begin
                unique case (cur_state.pending_kind)
                    KIND_LB:  wr_val = {{24{load_data[7]}}, load_data[7:0]};
                    KIND_LH:  wr_val = {{16{load_data[15]}}, load_data[15:0]};
                    KIND_LBU: wr_val = {24'h000000, load_data[7:0]};
                    KIND_LHU: wr_val = {16'h0000, load_data[15:0]};
                    default:  wr_val = load_data;
                endcase
                wr_req = 1'b1;
                wr_dst = cur_state.pending_register;
                next_state.load_pending = 1'b0;
                result.instr_address = cur_state.pc - 32'd4;
                npc = cur_state.pc;
            end
        end
        else if (cur_state.load_pending)
        begin
            result.status = ST_UNEXPECTED;
            npc = cur_state.pc;
        end
        else
        begin
            unique case (opc)
                OP_SPECIAL:
                begin
                    wr_dst = rd;
                    unique case (fn)
                        FN_SLL:  begin wr_req = 1'b1; wr_val = src_b << sh; end
                        FN_SRL:  begin wr_req = 1'b1; wr_val = src_b >> sh; end
                        FN_SRA:  begin wr_req = 1'b1; wr_val = word_t'($signed(src_b) >>> sh); end
                        FN_JR:   npc = src_a;
                        FN_JALR: begin npc = src_a; wr_req = 1'b1; wr_val = pc_plus4; end
                        FN_SYSCALL:
                        begin
                            result.status        = ST_SYSCALL;
                            result.call_number   = src_a;
                            result.call_argument = src_b;
                        end
                        FN_ADDU: begin wr_req = 1'b1; wr_val = src_a + src_b; end
                        FN_SUBU: begin wr_req = 1'b1; wr_val = src_a - src_b; end
                        FN_AND:  begin wr_req = 1'b1; wr_val = src_a & src_b; end
                        FN_OR:   begin wr_req = 1'b1; wr_val = src_a | src_b; end
                        FN_XOR:  begin wr_req = 1'b1; wr_val = src_a ^ src_b; end
                        FN_NOR:  begin wr_req = 1'b1; wr_val = ~(src_a | src_b); end
                        FN_SLT:
                        begin
                            wr_req = 1'b1;
                            wr_val = {31'd0, $signed(src_a) < $signed(src_b)};
                        end
                        FN_SLTU: begin wr_req = 1'b1; wr_val = {31'd0, src_a < src_b}; end
                        default: result.status = ST_ILLEGAL;
                    endcase
                end
                OP_J:   npc = jump_target;
                OP_JAL:
                begin
                    npc    = jump_target;
                    wr_req = 1'b1;
                    wr_dst = REG_RA;
                    wr_val = pc_plus4;
                end
                OP_BEQ: if (src_a == src_b) npc = branch_target;
                OP_BNE: if (src_a != src_b) npc = branch_target;
                OP_ADDIU: begin wr_req = 1'b1; wr_dst = rt; wr_val = src_a + simm; end
                OP_SLTI:
                begin
                    wr_req = 1'b1;
                    wr_dst = rt;
                    wr_val = {31'd0, $signed(src_a) < $signed(simm)};
                end
                OP_SLTIU: begin wr_req = 1'b1; wr_dst = rt; wr_val = {31'd0, src_a < simm}; end
                OP_ANDI:  begin wr_req = 1'b1; wr_dst = rt; wr_val = src_a & imm; end
                OP_ORI:   begin wr_req = 1'b1; wr_dst = rt; wr_val = src_a | imm; end
                OP_XORI:  begin wr_req = 1'b1; wr_dst = rt; wr_val = src_a ^ imm; end
                OP_LUI:
                begin
                    wr_req = 1'b1;
                    wr_dst = rt;
                    wr_val = {instruction[15:0], 16'h0000};
                end
                OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU:
                begin
                    result.status               = ST_LOAD_REQ;
                    result.mem_address          = src_a + simm;
                    next_state.load_pending     = 1'b1;
                    next_state.pending_register = rt;
                    unique case (opc)
                        OP_LB:
                        begin
                            next_state.pending_kind = KIND_LB;
                            result.access_size = ACC_BYTE;
                        end
                        OP_LH:
                        begin
                            next_state.pending_kind = KIND_LH;
                            result.access_size = ACC_HALF;
                        end
                        OP_LW:
                        begin
                            next_state.pending_kind = KIND_LW;
                            result.access_size = ACC_WORD;
                        end
                        OP_LBU:
                        begin
                            next_state.pending_kind = KIND_LBU;
                            result.access_size = ACC_BYTE;
                        end
                        default:
                        begin
                            next_state.pending_kind = KIND_LHU;
                            result.access_size = ACC_HALF;
                        end
                    endcase
                end
                OP_SB, OP_SH, OP_SW:
                begin
                    result.status      = ST_STORE_REQ;
                    result.mem_address = src_a + simm;
                    result.store_value = src_b;
                    unique case (opc)
                        OP_SB:   result.access_size = ACC_BYTE;
                        OP_SH:   result.access_size = ACC_HALF;
                        default: result.access_size = ACC_WORD;
                    endcase
                end
                default: result.status = ST_ILLEGAL;
            endcase
        end

        // An illegal word changes nothing.
        if (result.status == ST_ILLEGAL)
        begin
            npc    = cur_state.pc;
            wr_req = 1'b0;
        end

        // Drop writes to the zero register.
        if (wr_req && (wr_dst != '0))
        begin
            result.write_valid    = 1'b1;
            result.write_register = wr_dst;
            result.write_value    = wr_val;
        end

        next_state.pc        = npc;
        result.next_address  = npc;
    end

endmodule

// ----- sim/mips32_instruction_executor_core_test.sv -----
// Self-checking testbench for the integer instruction executor core.
module mips32_instruction_executor_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import iexec_pkg::*;

    localparam int CYCLE_LIMIT = 250000;
    localparam int PHASE_WORDS = 250;
    localparam int HOLD_CYCLES = 300;

    // Encodings that the core does not implement
    localparam logic [5:0] OP_UNUSED = 6'h3f;
    localparam logic [5:0] FN_UNUSED = 6'h3f;

    localparam logic [5:0] SPECIAL_FNS [14] = '{FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_JALR,
        FN_SYSCALL, FN_ADDU, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
    localparam logic [5:0] FLOW_ALU_OPS [11] = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDIU,
        OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI};
    localparam logic [5:0] LOAD_OPS [5] = '{OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU};
    localparam logic [5:0] STORE_OPS [3] = '{OP_SB, OP_SH, OP_SW};

    // Architectural shadow of the core plus the results it still owes
    class core_tracker;
        word_t      gpr [RF_DEPTH];
        word_t      pc;
        bit         load_pending;
        reg_addr_t  pend_reg;
        load_kind_t pend_kind;
        result_t    awaited_results [$];
        int         failures;
        int         checked;
        int         status_seen [6];

        function new();
            foreach (gpr[i])
                gpr[i] = '0;
            pc = START_ADDRESS_RESET;
            load_pending = 1'b0;
            pend_reg = '0;
            pend_kind = KIND_LB;
            failures = 0;
            checked = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function void restart(word_t addr);
            pc = addr;
            load_pending = 1'b0;
        endfunction

        function result_t execute_word(bit is_data, word_t ins, word_t rdata);
            result_t    r;
            logic [5:0] opc;
            logic [5:0] fn;
            reg_addr_t  rs;
            reg_addr_t  rt;
            reg_addr_t  rd;
            logic [4:0] sh;
            word_t      a;
            word_t      b;
            word_t      simm;
            word_t      zimm;
            word_t      npc;
            word_t      wval;
            bit         wr;
            reg_addr_t  dest;

            opc = ins[31:26];
            rs = ins[25:21];
            rt = ins[20:16];
            rd = ins[15:11];
            sh = ins[10:6];
            fn = ins[5:0];
            simm = {{16{ins[15]}}, ins[15:0]};
            zimm = {16'h0000, ins[15:0]};
            a = gpr[rs];
            b = gpr[rt];
            r = '0;
            r.status = ST_RETIRED;
            r.instr_address = pc;
            npc = pc + 32'd4;
            wr = 1'b0;
            dest = '0;
            wval = '0;

            if (is_data || load_pending) begin
                // out-of-order word: report it and leave the state alone
                if (!(is_data && load_pending)) begin
                    r.status = ST_UNEXPECTED;
                    r.next_address = pc;
                    return r;
                end
                case (pend_kind)
                    KIND_LB:  wval = {{24{rdata[7]}}, rdata[7:0]};
                    KIND_LH:  wval = {{16{rdata[15]}}, rdata[15:0]};
                    KIND_LBU: wval = {24'h0, rdata[7:0]};
                    KIND_LHU: wval = {16'h0, rdata[15:0]};
                    default:  wval = rdata;
                endcase
                load_pending = 1'b0;
                r.instr_address = pc - 32'd4;
                npc = pc;
                wr = 1'b1;
                dest = pend_reg;
            end else begin
                case (opc)
                    OP_SPECIAL: begin
                        wr = 1'b1;
                        dest = rd;
                        case (fn)
                            FN_SLL:  wval = b << sh;
                            FN_SRL:  wval = b >> sh;
                            FN_SRA:  wval = word_t'($signed(b) >>> sh);
                            FN_JR:
                            begin
                                npc = a;
                                wr = 1'b0;
                            end
                            FN_JALR:
                            begin
                                npc = a;
                                wval = pc + 32'd4;
                            end
                            FN_SYSCALL:
                            begin
                                r.status = ST_SYSCALL;
                                r.call_number = gpr[REG_V0];
                                r.call_argument = gpr[REG_A0];
                                wr = 1'b0;
                            end
                            FN_ADDU: wval = a + b;
                            FN_SUBU: wval = a - b;
                            FN_AND:  wval = a & b;
                            FN_OR:   wval = a | b;
                            FN_XOR:  wval = a ^ b;
                            FN_NOR:  wval = ~(a | b);
                            FN_SLT:  wval = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                            FN_SLTU: wval = (a < b) ? 32'd1 : 32'd0;
                            default:
                            begin
                                r.status = ST_ILLEGAL;
                                wr = 1'b0;
                            end
                        endcase
                    end
                    OP_J:
                        npc = {npc[31:28], ins[25:0], 2'b00};
                    OP_JAL:
                    begin
                        npc = {npc[31:28], ins[25:0], 2'b00};
                        wr = 1'b1;
                        dest = REG_RA;
                        wval = pc + 32'd4;
                    end
                    OP_BEQ:
                        if (a == b)
                            npc = pc + 32'd4 + (simm << 2);
                    OP_BNE:
                        if (a != b)
                            npc = pc + 32'd4 + (simm << 2);
                    OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI:
                    begin
                        wr = 1'b1;
                        dest = rt;
                        case (opc)
                            OP_ADDIU: wval = a + simm;
                            OP_SLTI:  wval = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
                            OP_SLTIU: wval = (a < simm) ? 32'd1 : 32'd0;
                            OP_ANDI:  wval = a & zimm;
                            OP_ORI:   wval = a | zimm;
                            OP_XORI:  wval = a ^ zimm;
                            default:  wval = {ins[15:0], 16'h0000};
                        endcase
                    end
                    OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU:
                    begin
                        r.status = ST_LOAD_REQ;
                        load_pending = 1'b1;
                        pend_reg = rt;
                        case (opc)
                            OP_LB:   pend_kind = KIND_LB;
                            OP_LH:   pend_kind = KIND_LH;
                            OP_LW:   pend_kind = KIND_LW;
                            OP_LBU:  pend_kind = KIND_LBU;
                            default: pend_kind = KIND_LHU;
                        endcase
                        r.mem_address = a + simm;
                        r.access_size = (opc == OP_LB || opc == OP_LBU) ? ACC_BYTE
                                      : (opc == OP_LW) ? ACC_WORD : ACC_HALF;
                    end
                    OP_SB, OP_SH, OP_SW:
                    begin
                        r.status = ST_STORE_REQ;
                        r.mem_address = a + simm;
                        r.access_size = (opc == OP_SB) ? ACC_BYTE
                                      : (opc == OP_SH) ? ACC_HALF : ACC_WORD;
                        r.store_value = b;
                    end
                    default:
                        r.status = ST_ILLEGAL;
                endcase
            end

            if (r.status == ST_ILLEGAL)
                npc = pc;
            pc = npc;
            r.next_address = npc;
            // drop writes to r0
            if (wr && dest != '0) begin
                gpr[dest] = wval;
                r.write_valid = 1'b1;
                r.write_register = dest;
                r.write_value = wval;
            end
            return r;
        endfunction

        function void take_word(bit is_data, word_t ins, word_t rdata);
            result_t r;

            r = execute_word(is_data, ins, rdata);
            status_seen[int'(r.status)]++;
            awaited_results.push_back(r);
        endfunction

        function void retire_result(result_t got);
            result_t want;
            string   diffs;

            if (awaited_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result word with none outstanding: status %0d pc %h",
                             $realtime, got.status, got.instr_address);
                return;
            end
            want = awaited_results.pop_front();
            checked++;
            diffs = "";
            if (got.status !== want.status)
                diffs = {diffs, $sformatf(" status %0d/%0d", want.status, got.status)};
            if (got.instr_address !== want.instr_address)
                diffs = {diffs, $sformatf(" instr_address %h/%h",
                                          want.instr_address, got.instr_address)};
            if (got.next_address !== want.next_address)
                diffs = {diffs, $sformatf(" next_address %h/%h",
                                          want.next_address, got.next_address)};
            if (got.write_valid !== want.write_valid)
                diffs = {diffs, $sformatf(" write_valid %0d/%0d",
                                          want.write_valid, got.write_valid)};
            if (got.write_register !== want.write_register)
                diffs = {diffs, $sformatf(" write_register %0d/%0d",
                                          want.write_register, got.write_register)};
            if (got.write_value !== want.write_value)
                diffs = {diffs, $sformatf(" write_value %h/%h",
                                          want.write_value, got.write_value)};
            if (got.mem_address !== want.mem_address)
                diffs = {diffs, $sformatf(" mem_address %h/%h",
                                          want.mem_address, got.mem_address)};
            if (got.access_size !== want.access_size)
                diffs = {diffs, $sformatf(" access_size %0d/%0d",
                                          want.access_size, got.access_size)};
            if (got.store_value !== want.store_value)
                diffs = {diffs, $sformatf(" store_value %h/%h",
                                          want.store_value, got.store_value)};
            if (got.call_number !== want.call_number)
                diffs = {diffs, $sformatf(" call_number %h/%h",
                                          want.call_number, got.call_number)};
            if (got.call_argument !== want.call_argument)
                diffs = {diffs, $sformatf(" call_argument %h/%h",
                                          want.call_argument, got.call_argument)};
            if (diffs != "") begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch at pc %h (expected/actual):%s",
                             $realtime, want.instr_address, diffs);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [31:0] cfg_write_data;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [31:0] instruction;
    logic [31:0] load_data;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [31:0] instr_address;
    logic [31:0] next_address;
    logic        write_valid;
    logic [4:0]  write_register;
    logic [31:0] write_value;
    logic [31:0] mem_address;
    logic [1:0]  access_size;
    logic [31:0] store_value;
    logic [31:0] call_number;
    logic [31:0] call_argument;

    logic        rx_stall;
    logic        long_hold;
    int          max_gap = 14;
    bit          hold_go = 1'b0;
    int          cycle_count = 0;
    core_tracker sb = new();

    assign out_stall = rx_stall | long_hold;

    mips32_instruction_executor_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .instruction    (instruction),
        .load_data      (load_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .instr_address  (instr_address),
        .next_address   (next_address),
        .write_valid    (write_valid),
        .write_register (write_register),
        .write_value    (write_value),
        .mem_address    (mem_address),
        .access_size    (access_size),
        .store_value    (store_value),
        .call_number    (call_number),
        .call_argument  (call_argument)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic word_t enc_r(logic [5:0] fn, int rs, int rt, int rd, int sh);
        return {OP_SPECIAL, 5'(rs), 5'(rt), 5'(rd), 5'(sh), fn};
    endfunction

    function automatic word_t enc_i(logic [5:0] opc, int rs, int rt, logic [15:0] imm);
        return {opc, 5'(rs), 5'(rt), imm};
    endfunction

    function automatic word_t random_instruction();
        int    pick;
        word_t w;

        pick = $urandom_range(0, 99);
        w = $urandom;
        if (pick < 35)
            w[5:0] = SPECIAL_FNS[$urandom_range(0, 13)];
        if (pick < 35)
            w[31:26] = OP_SPECIAL;
        else if (pick < 70)
            w[31:26] = FLOW_ALU_OPS[$urandom_range(0, 10)];
        else if (pick < 85)
            w[31:26] = LOAD_OPS[$urandom_range(0, 4)];
        else if (pick < 93)
            w[31:26] = STORE_OPS[$urandom_range(0, 2)];
        // otherwise keep the raw word, mostly unimplemented encodings
        return w;
    endfunction

    task automatic send_word(bit is_data, word_t ins, word_t rdata);
        int gap;

        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= is_data;
        instruction <= ins;
        load_data <= rdata;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.take_word(is_data, ins, rdata);
    endtask

    task automatic send_instruction(word_t ins);
        send_word(1'b0, ins, $urandom);
    endtask

    task automatic send_load_data(word_t rdata);
        send_word(1'b1, $urandom, rdata);
    endtask

    // Mostly well-formed traffic: answer a pending load with data, else execute
    task automatic send_random();
        bit noise;

        noise = ($urandom_range(0, 99) < 4);
        if (sb.load_pending ^ noise)
            send_load_data($urandom);
        else
            send_instruction(random_instruction());
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_start(word_t addr);
        cfg_write_en <= 1'b1;
        cfg_write_data <= addr;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sb.restart(addr);
        repeat (2) @(posedge clk);
    endtask

    task automatic run_directed();
        send_instruction(enc_i(OP_LUI, 0, 1, 16'hffff));
        send_instruction(enc_i(OP_ORI, 1, 1, 16'hffff));
        send_instruction(enc_i(OP_ADDIU, 0, REG_V0, 16'h8000));
        send_instruction(enc_i(OP_ADDIU, 0, 3, 16'h0001));
        send_instruction(enc_r(FN_SLL, 0, 3, REG_A0, 31));
        send_instruction(enc_r(FN_SRA, 0, REG_A0, 5, 31));
        send_instruction(enc_r(FN_SRL, 0, REG_A0, 6, 31));
        send_instruction(enc_r(FN_SRA, 0, REG_A0, 7, 0));
        send_instruction(enc_i(OP_SLTIU, 3, 8, 16'hffff));
        send_instruction(enc_i(OP_SLTI, REG_A0, 9, 16'h0000));
        send_instruction(enc_r(FN_ADDU, 1, 1, 0, 0));
        send_instruction(enc_r(FN_SYSCALL, 0, 0, 0, 0));
        // sign and zero extension, junk above the used bits
        send_instruction(enc_i(OP_LB, 1, 13, 16'h8000));
        send_load_data(32'h1234_5680);
        send_instruction(enc_i(OP_LHU, REG_V0, 14, 16'h7fff));
        send_load_data(32'habcd_8001);
        send_instruction(enc_i(OP_LW, 0, 0, 16'h0000));
        send_load_data(32'hffff_ffff);
        // instruction while a load is outstanding, then data with none outstanding
        send_instruction(enc_i(OP_LH, 3, 15, 16'hfffc));
        send_instruction(enc_i(OP_ADDIU, 0, 16, 16'h0001));
        send_load_data(32'h0000_8000);
        send_load_data(32'h0000_0001);
        send_instruction(enc_i(OP_SW, 1, REG_A0, 16'h8000));
        send_instruction(enc_i(OP_BEQ, 1, 5, 16'h8000));
        send_instruction({OP_JAL, 26'h3ff_ffff});
        send_instruction(enc_r(FN_JALR, REG_RA, 0, 16, 0));
        send_instruction({OP_UNUSED, 26'h3ff_ffff});
        send_instruction(enc_r(FN_UNUSED, 1, 2, 3, 4));
    endtask

    // Output side: random stall per result word, then take it
    initial
    begin
        int    wait_cycles;
        result_t got;

        rx_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            wait_cycles = $urandom_range(0, max_gap);
            if (wait_cycles > 0) begin
                rx_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
                rx_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid === 1'b1 && out_stall === 1'b0));
            got.status = status_t'(status);
            got.instr_address = instr_address;
            got.next_address = next_address;
            got.write_valid = write_valid;
            got.write_register = write_register;
            got.write_value = write_value;
            got.mem_address = mem_address;
            got.access_size = access_size;
            got.store_value = store_value;
            got.call_number = call_number;
            got.call_argument = call_argument;
            sb.retire_result(got);
        end
    end

    // Hold the output off long enough for the core to back up into its input
    initial
    begin
        long_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin
        word_t restart_points [5];

        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        in_valid = 1'b0;
        op = 1'b0;
        instruction = '0;
        load_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        restart_points = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_fffc, $urandom,
                           START_ADDRESS_RESET};
        for (int ph = 0; ph < 5; ph++) begin
            settle();
            write_start(restart_points[ph]);
            max_gap = (ph == 1 || ph == 2) ? 0 : 14;
            if (ph == 2)
                hold_go = 1'b1;
            repeat (PHASE_WORDS) send_random();
        end
        max_gap = 14;
        settle();

        $display("checked %0d result words: %0d retired, %0d load, %0d store, %0d syscall,",
                 sb.checked, sb.status_seen[ST_RETIRED], sb.status_seen[ST_LOAD_REQ],
                 sb.status_seen[ST_STORE_REQ], sb.status_seen[ST_SYSCALL]);
        $display("%0d illegal, %0d out of order; 5 restart addresses, one long output hold",
                 sb.status_seen[ST_ILLEGAL], sb.status_seen[ST_UNEXPECTED]);
        if (sb.failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
